[hdl/acbc_pkg.sv]
// ----------------------------------------------------------------------------
// acbc_pkg
// Shared types, codes, S-box tables and AES round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package acbc_pkg;

  localparam int ROUNDS    = 10;
  localparam int RK_IDX_W  = $clog2(ROUNDS + 1);
  localparam int CFG_IDX_W = 3;
  localparam int PADDR_W   = 6;
  localparam int PDATA_W   = 64;

  typedef enum logic [1:0] {
    MODE_ENC    = 2'd0,
    MODE_DEC    = 2'd1,
    MODE_SINGLE = 2'd2,
    MODE_SPARE  = 2'd3
  } acbc_mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY_START,
    S_KEY,
    S_ADDKEY,
    S_ROUND,
    S_DONE,
    S_PAD
  } acbc_state_t;

  typedef struct packed {
    logic                load;
    logic                key_start;
    logic                key_step;
    logic                add_key;
    logic                round;
    logic                out_load;
    logic                pad_load;
    logic [RK_IDX_W-1:0] idx;
  } acbc_cmd_t;

  typedef struct packed {
    logic out_stall;
    logic need_pad;
  } acbc_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_REV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [ROUNDS+1] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  localparam logic [7:0] PAD_FULL = 8'h10;

  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    get_byte = s[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    shift_sub = t;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*((c + r) % 4)) -: 8] = SBOX_REV[get_byte(s, r + 4*c)];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a0 = get_byte(s, 4*c + r);
        a1 = get_byte(s, 4*c + (r + 1) % 4);
        a2 = get_byte(s, 4*c + (r + 2) % 4);
        a3 = get_byte(s, 4*c + (r + 3) % 4);
        t[127-8*(4*c+r) -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      end
    end
    mix = t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = get_byte(s, 4*c + k);
        x2[k] = xtime(a[k]);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
      end
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] =
          (x8[r] ^ x4[r] ^ x2[r]) ^
          (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
          (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
          (x8[(r+3)%4] ^ a[(r+3)%4]);
      end
    end
    inv_mix = t;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    key_next = {n0, n1, n2, n3};
  endfunction

endpackage

`default_nettype wire

[hdl/acbc_if.sv]
// ----------------------------------------------------------------------------
// acbc_in_if / acbc_out_if
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
`default_nettype none

interface acbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic        chain_start;
  logic        last_block;
  logic [4:0]  byte_count;

  modport source (output valid, data_high, data_low, chain_start, last_block, byte_count,
                  input ready);
  modport sink   (input valid, data_high, data_low, chain_start, last_block, byte_count,
                  output ready);
endinterface

interface acbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic [4:0]  out_bytes;
  logic        pad_error;
  logic        last;

  modport source (output valid, out_high, out_low, out_bytes, pad_error, last,
                  input ready);
  modport sink   (input valid, out_high, out_low, out_bytes, pad_error, last,
                  output ready);
endinterface

`default_nettype wire

[hdl/acbc_ctrl.sv]
// ----------------------------------------------------------------------------
// acbc_ctrl
// Sequencer: key expansion, initial key add, ten rounds, result handoff, pad block.
// ----------------------------------------------------------------------------
`default_nettype none

module acbc_ctrl
  import acbc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       key_write,
  input  wire acbc_stat_t stat,
  output acbc_cmd_t       cmd,
  output logic            keys_ready
);

  acbc_state_t         state, state_next;
  logic [RK_IDX_W-1:0] cnt, cnt_next;
  logic                keys_ready_next;

  localparam logic [RK_IDX_W-1:0] LAST_IDX = RK_IDX_W'(ROUNDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      keys_ready <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      keys_ready <= keys_ready_next;
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    keys_ready_next = keys_ready;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.idx         = cnt;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = keys_ready ? S_ADDKEY : S_KEY_START;
        end
      end
      S_KEY_START: begin
        cmd.key_start = 1'b1;
        cnt_next      = RK_IDX_W'(1);
        state_next    = S_KEY;
      end
      S_KEY: begin
        cmd.key_step = 1'b1;
        if (cnt == LAST_IDX) begin
          keys_ready_next = 1'b1;
          state_next      = S_ADDKEY;
        end else begin
          cnt_next = cnt + RK_IDX_W'(1);
        end
      end
      S_ADDKEY: begin
        cmd.add_key = 1'b1;
        cnt_next    = RK_IDX_W'(1);
        state_next  = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + RK_IDX_W'(1);
        end
      end
      S_DONE: begin
        if (!stat.out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = stat.need_pad ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        cmd.pad_load = 1'b1;
        state_next   = S_ADDKEY;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // a key change invalidates the schedule; the user writes keys only while idle, not enforced here
    if (key_write) begin
      keys_ready_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

[hdl/acbc_datapath.sv]
// ----------------------------------------------------------------------------
// acbc_datapath
// Block state, round key schedule, chain value and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module acbc_datapath
  import acbc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire acbc_cmd_t     cmd,
  output acbc_stat_t         stat,
  input  wire logic [127:0]  key,
  input  wire logic [127:0]  iv,
  input  wire acbc_mode_t    mode,
  input  wire logic [63:0]   data_high,
  input  wire logic [63:0]   data_low,
  input  wire logic          chain_start,
  input  wire logic          last_block,
  input  wire logic [4:0]    byte_count,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [63:0]        out_high,
  output logic [63:0]        out_low,
  output logic [4:0]         out_bytes,
  output logic               pad_error,
  output logic               last
);

  logic [127:0] st, chain, xc, kreg;
  logic [127:0] rk [ROUNDS+1];
  acbc_mode_t   m_mode;
  logic         m_last, m_full, m_padph;

  logic [127:0] blk, chain_sel, rk_enc, rk_dec, enc_t, dec_t, res;
  logic [7:0]   pbyte;
  logic [4:0]   res_bytes;
  logic         res_err, res_last;

  localparam logic [RK_IDX_W-1:0] LAST_IDX = RK_IDX_W'(ROUNDS);

  // pad a short final block in encrypt mode
  always_comb begin
    blk = {data_high, data_low};
    if (mode == MODE_ENC && last_block && !byte_count[4]) begin
      for (int i = 0; i < 16; i++) begin
        if (5'(i) >= byte_count) begin
          blk[127-8*i -: 8] = 8'd16 - {3'd0, byte_count};
        end
      end
    end
  end

  assign chain_sel = chain_start ? iv : chain;
  assign rk_enc    = rk[cmd.idx];
  assign rk_dec    = rk[LAST_IDX - cmd.idx];
  assign enc_t     = (cmd.idx == LAST_IDX) ? shift_sub(st) : mix(shift_sub(st));
  assign dec_t     = inv_shift_sub(st) ^ rk_dec;

  assign res   = (m_mode == MODE_DEC) ? (st ^ xc) : st;
  assign pbyte = res[7:0];

  always_comb begin
    res_bytes = 5'd16;
    res_err   = 1'b0;
    res_last  = 1'b1;
    case (m_mode)
      MODE_ENC: begin
        res_last = m_last && (!m_full || m_padph);
      end
      MODE_DEC: begin
        res_last = m_last;
        if (m_last) begin
          if (pbyte == 8'd0 || pbyte > 8'd16) begin
            res_bytes = 5'd0;
            res_err   = 1'b1;
          end else begin
            res_bytes = 5'(8'd16 - pbyte);
          end
        end
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
  end

  assign stat.out_stall = out_valid && !out_ready;
  assign stat.need_pad  = (m_mode == MODE_ENC) && m_last && m_full && !m_padph;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_mode  <= mode;
      m_last  <= last_block;
      m_full  <= byte_count[4];
      m_padph <= 1'b0;
      if (chain_start) begin
        chain <= iv;
      end
      case (mode)
        MODE_ENC: begin
          st <= blk ^ chain_sel;
        end
        MODE_DEC: begin
          st    <= blk;
          xc    <= chain_sel;
          chain <= blk;
        end
        default: begin
          st <= blk;
        end
      endcase
    end
    if (cmd.key_start) begin
      kreg  <= key;
      rk[0] <= key;
    end
    if (cmd.key_step) begin
      kreg        <= key_next(kreg, RCON[cmd.idx]);
      rk[cmd.idx] <= key_next(kreg, RCON[cmd.idx]);
    end
    if (cmd.add_key) begin
      st <= st ^ ((m_mode == MODE_DEC) ? rk[LAST_IDX] : rk[0]);
    end
    if (cmd.round) begin
      if (m_mode == MODE_DEC) begin
        st <= (cmd.idx == LAST_IDX) ? dec_t : inv_mix(dec_t);
      end else begin
        st <= enc_t ^ rk_enc;
      end
    end
    if (cmd.pad_load) begin
      m_padph <= 1'b1;
      st      <= {16{PAD_FULL}} ^ chain;
    end
    if (cmd.out_load) begin
      {out_high, out_low} <= res;
      out_bytes           <= res_bytes;
      pad_error           <= res_err;
      last                <= res_last;
      if (m_mode == MODE_ENC) begin
        chain <= st;
      end
    end
    if (rst) begin
      chain <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hdl/aes128_cbc_cipher_unit.sv]
// ----------------------------------------------------------------------------
// aes128_cbc_cipher_unit
// AES-128 block engine with CBC chaining, PKCS7 padding and pad checking.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------------------
//  in_ch     sink       valid/ready            data_high/low, chain_start,
//                                              last_block, byte_count
//  out_ch    source     valid/ready            out_high/low, out_bytes,
//                                              pad_error, last
//  apb       slave      psel/penable/pready    paddr, pwdata, prdata (64 bit)
//
//  After a block is accepted it runs one initial key add and ten rounds on
//  the single round unit, then one handoff loads the result; the next block
//  can be accepted in the cycle after the handoff, so one block is in flight.
//  After reset or a key write the first block first runs key expansion,
//  one round key per cycle. A full final block in encrypt mode runs a
//  second pad block. The next block is accepted while a result still waits
//  in the output register; a stalled output holds the handoff, and with it
//  the next block. Reset is synchronous; no clearing pass is needed.
//
`default_nettype none

module aes128_cbc_cipher_unit
  import acbc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  acbc_in_if.sink                 in_ch,
  acbc_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [63:0]          key_high, key_low, iv_high, iv_low;
  acbc_mode_t           mode;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr, key_write, keys_ready, in_ready;
  acbc_cmd_t            cmd;
  acbc_stat_t           stat;

  // register file: byte address 8 * index
  assign cfg_idx   = paddr[PADDR_W-1:3];
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign key_write = cfg_wr && (cfg_idx == REG_KEY_HIGH || cfg_idx == REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      iv_high  <= '0;
      iv_low   <= '0;
      mode     <= MODE_ENC;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY_HIGH: key_high <= pwdata;
        REG_KEY_LOW:  key_low  <= pwdata;
        REG_IV_HIGH:  iv_high  <= pwdata;
        REG_IV_LOW:   iv_low   <= pwdata;
        REG_MODE:     mode     <= acbc_mode_t'(pwdata[1:0]);
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_LOW:  prdata = key_low;
      REG_IV_HIGH:  prdata = iv_high;
      REG_IV_LOW:   prdata = iv_low;
      REG_MODE:     prdata = {{(PDATA_W-2){1'b0}}, mode};
      default:      prdata = '0;
    endcase
  end

  assign in_ch.ready = in_ready;

  acbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .key_write  (key_write),
    .stat       (stat),
    .cmd        (cmd),
    .keys_ready (keys_ready)
  );

  acbc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .key         ({key_high, key_low}),
    .iv          ({iv_high, iv_low}),
    .mode        (mode),
    .data_high   (in_ch.data_high),
    .data_low    (in_ch.data_low),
    .chain_start (in_ch.chain_start),
    .last_block  (in_ch.last_block),
    .byte_count  (in_ch.byte_count),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_high    (out_ch.out_high),
    .out_low     (out_ch.out_low),
    .out_bytes   (out_ch.out_bytes),
    .pad_error   (out_ch.pad_error),
    .last        (out_ch.last)
  );

  // one block in flight: acceptance closes the input until the block is done
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("input accepted while a block is in flight");

  // a bad pad byte reports no bytes and ends the message
  a_pad_error_result: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.pad_error) |-> (out_ch.out_bytes == 5'd0 && out_ch.last))
    else $error("pad error without empty final result");

  // a key write forces re-expansion before the next block
  a_key_invalidate: assert property (@(posedge clk) disable iff (rst)
    key_write |=> !keys_ready)
    else $error("round keys still marked ready after key write");

endmodule

`default_nettype wire
